/* sv/rpn_pkg.sv */
// shared types and constants of the rpn evaluator
`default_nettype none
package rpn_pkg;

    localparam int SYM_W    = 8;
    localparam int OUT_W    = 32;
    localparam int STATUS_W = 3;
    localparam int BAL_W    = 16;

    localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
    localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CH_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_DIVZERO = 3'd2,
        ST_UNDER   = 3'd3,
        ST_OVER    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_EXEC   = 6'b000100,
        S_WAIT   = 6'b001000,
        S_TOP    = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic take_in;
        logic decode;
        logic rd_ops;
        logic wr_alu;
        logic set_dz;
        logic start_unit;
        logic wr_unit;
        logic rd_top;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_op;
        t_op  op;
        logic last;
        logic err_ok;
        logic lt2;
        logic rhs_zero;
        logic unit_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* sv/rpn_mdu.sv */
// iterative shift-add multiplier and restoring signed divider
`default_nettype none
module rpn_mdu
    import rpn_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire t_op                    i_op,
    input  wire logic [VALUE_WIDTH-1:0] i_lhs,
    input  wire logic [VALUE_WIDTH-1:0] i_rhs,
    output logic                        o_done,
    output logic [VALUE_WIDTH-1:0]      o_result
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W) + 1;

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_is_div, n_is_div;
    logic            r_neg, n_neg;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [W-1:0]    r_acc, n_acc;

    logic [W-1:0]    lhs_mag, rhs_mag;
    logic [W:0]      rem_sh, rem_sub;

    assign lhs_mag = i_lhs[W-1] ? (~i_lhs + 1'b1) : i_lhs;
    assign rhs_mag = i_rhs[W-1] ? (~i_rhs + 1'b1) : i_rhs;
    assign rem_sh  = {r_acc, r_b[W-1]};
    assign rem_sub = rem_sh - {1'b0, r_a};

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_is_div = r_is_div;
        n_neg    = r_neg;
        n_a      = r_a;
        n_b      = r_b;
        n_acc    = r_acc;
        if (i_start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_acc    = '0;
            n_is_div = (i_op == OP_DIV);
            if (i_op == OP_DIV) begin
                n_a   = rhs_mag;
                n_b   = lhs_mag;
                n_neg = i_lhs[W-1] ^ i_rhs[W-1];
            end else begin
                n_a   = i_lhs;
                n_b   = i_rhs;
                n_neg = 1'b0;
            end
        end else if (r_busy) begin
            if (r_is_div) begin
                // partial remainder stays below the divisor, so it fits in W bits
                if (!rem_sub[W]) begin
                    n_acc = rem_sub[W-1:0];
                    n_b   = {r_b[W-2:0], 1'b1};
                end else begin
                    n_acc = rem_sh[W-1:0];
                    n_b   = {r_b[W-2:0], 1'b0};
                end
            end else begin
                if (r_b[0]) begin
                    n_acc = r_acc + r_a;
                end
                n_a = {r_a[W-2:0], 1'b0};
                n_b = {1'b0, r_b[W-1:1]};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt    <= n_cnt;
        r_is_div <= n_is_div;
        r_neg    <= n_neg;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
    end

    assign o_done   = r_done;
    assign o_result = !r_is_div ? r_acc : (r_neg ? (~r_b + 1'b1) : r_b);

endmodule
`default_nettype wire

/* sv/rpn_dpath.sv */
// operand stack, counters, error flag, arithmetic and result register
`default_nettype none
module rpn_dpath
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    input  wire logic [SYM_W-1:0]    i_symbol,
    input  wire logic                i_last,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic signed [OUT_W-1:0]  o_value,
    output logic [STATUS_W-1:0]      o_status
);

    localparam int W  = VALUE_WIDTH;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [W-1:0]          r_stack [STACK_DEPTH];
    logic [CW-1:0]         r_count;
    logic [BAL_W-1:0]      r_bal;
    t_status               r_err;
    logic [SYM_W-1:0]      r_sym;
    logic                  r_last;
    logic [W-1:0]          r_rd_a;  // top entry, right operand
    logic [W-1:0]          r_rd_b;  // entry below, left operand
    logic                  r_out_valid;
    logic signed [OUT_W-1:0] r_value;
    t_status               r_status;

    logic [CW-1:0]         cnt_m1, cnt_m2;
    logic [AW-1:0]         addr_top, addr_nxt, wr_addr;
    logic                  wr_en;
    logic [W-1:0]          wr_data, alu_res, unit_res, digit_val;
    logic                  unit_done;
    t_op                   op;
    logic                  is_space, is_digit, is_op, full;
    t_status               fin_status;

    assign cnt_m1   = r_count - 1'b1;
    assign cnt_m2   = r_count - 2'd2;
    assign addr_top = cnt_m1[AW-1:0];
    assign addr_nxt = cnt_m2[AW-1:0];
    assign full     = (r_count == CW'(STACK_DEPTH));

    assign is_space = ((r_sym >= CH_TAB) && (r_sym <= CH_CR)) || (r_sym == CH_SPACE);
    assign is_digit = (r_sym >= CH_ZERO) && (r_sym <= CH_NINE);
    assign is_op    = (r_sym == CH_PLUS) || (r_sym == CH_MINUS) ||
                      (r_sym == CH_STAR) || (r_sym == CH_SLASH);

    always_comb begin
        unique case (r_sym)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            default:  op = OP_DIV;
        endcase
    end

    assign digit_val = {{(W-4){1'b0}}, 4'(r_sym - CH_ZERO)};
    assign alu_res   = (op == OP_SUB) ? (r_rd_b - r_rd_a) : (r_rd_b + r_rd_a);

    rpn_mdu #(
        .VALUE_WIDTH (W)
    ) u_mdu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start_unit),
        .i_op     (op),
        .i_lhs    (r_rd_b),
        .i_rhs    (r_rd_a),
        .o_done   (unit_done),
        .o_result (unit_res)
    );

    // single write port: push of a digit or replacement by an operation result
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_nxt;
        wr_data = alu_res;
        if (i_cmd.decode && is_digit && (r_err == ST_OK) && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = digit_val;
        end else if (i_cmd.wr_alu) begin
            wr_en = 1'b1;
        end else if (i_cmd.wr_unit) begin
            wr_en   = 1'b1;
            wr_data = unit_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_stack[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_ops) begin
            r_rd_a <= r_stack[addr_top];
            r_rd_b <= r_stack[addr_nxt];
        end else if (i_cmd.rd_top) begin
            r_rd_a <= r_stack[addr_top];
        end
    end

    always_comb begin
        if ((r_err == ST_INVALID) || (r_bal != BAL_W'(1))) begin
            fin_status = ST_INVALID;
        end else begin
            fin_status = r_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bal       <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.decode) begin
                if (is_digit) begin
                    r_bal <= r_bal + 1'b1;
                    if (r_err == ST_OK) begin
                        if (full) begin
                            r_err <= ST_OVER;
                        end else begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end else if (is_op) begin
                    r_bal <= r_bal - 1'b1;
                    if ((r_err == ST_OK) && (r_count < CW'(2))) begin
                        r_err <= ST_UNDER;
                    end
                end else if (!is_space) begin
                    r_err <= ST_INVALID;
                end
            end
            if (i_cmd.wr_alu || i_cmd.wr_unit) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.set_dz) begin
                r_err <= ST_DIVZERO;
            end
            if (i_cmd.emit) begin
                r_count     <= '0;
                r_bal       <= '0;
                r_err       <= ST_OK;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_in) begin
            r_sym  <= i_symbol;
            r_last <= i_last;
        end
        if (i_cmd.emit) begin
            r_status <= fin_status;
            if ((fin_status == ST_OK) && (r_count != '0)) begin
                r_value <= OUT_W'(signed'(r_rd_a));
            end else begin
                r_value <= '0;
            end
        end
    end

    always_comb begin
        o_sts.is_op     = is_op;
        o_sts.op        = op;
        o_sts.last      = r_last;
        o_sts.err_ok    = (r_err == ST_OK);
        o_sts.lt2       = (r_count < CW'(2));
        o_sts.rhs_zero  = (r_rd_a == '0);
        o_sts.unit_done = unit_done;
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;

endmodule
`default_nettype wire

/* sv/rpn_ctrl.sv */
// sequencing state machine of the rpn evaluator
`default_nettype none
module rpn_ctrl
    import rpn_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                if (i_sts.is_op && i_sts.err_ok && !i_sts.lt2) begin
                    o_cmd.rd_ops = 1'b1;
                    n_state      = S_EXEC;
                end else if (i_sts.last) begin
                    n_state = S_TOP;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EXEC: begin
                n_state = i_sts.last ? S_TOP : S_IDLE;
                unique case (i_sts.op)
                    OP_ADD, OP_SUB: o_cmd.wr_alu = 1'b1;
                    OP_DIV: begin
                        if (i_sts.rhs_zero) begin
                            o_cmd.set_dz = 1'b1;
                        end else begin
                            o_cmd.start_unit = 1'b1;
                            n_state          = S_WAIT;
                        end
                    end
                    default: begin
                        o_cmd.start_unit = 1'b1;
                        n_state          = S_WAIT;
                    end
                endcase
            end
            S_WAIT: begin
                if (i_sts.unit_done) begin
                    o_cmd.wr_unit = 1'b1;
                    n_state       = i_sts.last ? S_TOP : S_IDLE;
                end
            end
            S_TOP: begin
                o_cmd.rd_top = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

/* sv/rpn_stack_evaluator_unit.sv */
// steps: a character is taken and decoded; a valid add or subtract then executes, and a
// multiply or non-zero divide also waits on the mul/div unit; a final character adds a
// top-of-stack read and result load before o_out_valid
// one transaction in flight at a time; a finished result may wait while the next is taken
// reset: i_rst_n synchronous active low, clears controller, counters, error and out valid
// stack memory content is undefined after reset and needs no clearing pass
`default_nettype none
module rpn_stack_evaluator_unit
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input channel: one character per transaction
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [SYM_W-1:0]    i_symbol,
    input  wire logic                i_last,
    // output channel: one result per expression
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [OUT_W-1:0]  o_value,
    output logic [STATUS_W-1:0]      o_status
);

    // command and status bundles between controller and datapath
    t_cmd cmd;
    t_sts sts;

    // controller: accepts a character, then steps decode, operand fetch,
    // execute and, for multiply or divide, a wait for the mul/div unit, and on the final character
    // reads the top of stack and loads the output register
    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // datapath: stack memory with two registered read ports, stack count,
    // digit balance, sticky error, adder, iterative mul/div and output register
    rpn_dpath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_value     (o_value),
        .o_status    (o_status)
    );

endmodule
`default_nettype wire

/* sv/rpn_chk.sv */
// port-level checker for the rpn evaluator and its bind
`default_nettype none
module rpn_chk
    import rpn_pkg::*;
(
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    o_in_ready,
    input wire logic                    o_out_valid,
    input wire logic                    i_out_ready,
    input wire logic signed [OUT_W-1:0] o_value,
    input wire logic [STATUS_W-1:0]     o_status
);

    // no result straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value) && $stable(o_status))
        else $error("stalled result changed");

    // error results carry a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_value == '0))
        else $error("non-zero value with error status");

    // a new result is loaded only while the input side is busy
    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while idle");

    // an accepted character keeps the input side busy for the next cycle
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready straight after a transaction");

endmodule

bind rpn_stack_evaluator_unit rpn_chk u_rpn_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_value     (o_value),
    .o_status    (o_status)
);
`default_nettype wire

/* tb/tb_top.sv */
// self-checking testbench for the rpn stack evaluator: scripted and random expressions
`timescale 1ns / 100ps
module tb_top
    import rpn_pkg::*;
();

    localparam int CALC_DEPTH   = 16;
    localparam int HOLD_CYCLES  = 400;      // long output hold-off, fills the block
    localparam int DRAIN_CYCLES = 80;       // quiet time after the last result
    localparam int TIMEOUT_NS   = 4000000;  // simulation time limit, in nanoseconds
    localparam int WELL_CHARS   = 1500;     // characters before the broken phase
    localparam int TOTAL_CHARS  = 1850;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        t_status                 status;
    } t_eval_result;

    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       in_valid   = 1'b0;
    logic [SYM_W-1:0]           in_symbol  = CH_SPACE;
    logic                       in_last    = 1'b0;
    logic                       out_ready  = 1'b0;
    logic                       in_ready;
    logic                       out_valid;
    logic signed [OUT_W-1:0]    out_value;
    logic [STATUS_W-1:0]        out_status;

    // evaluator shadow state
    logic [OUT_W-1:0]           calc_stack [CALC_DEPTH];
    int                         calc_count = 0;
    logic [BAL_W-1:0]           digit_surplus = '0;
    t_status                    first_error = ST_OK;

    t_eval_result               pending_results [$];
    logic [SYM_W-1:0]           expr_chars [$];
    int                         chars_sent = 0;
    int                         err_count  = 0;
    int                         burst_left = 0;
    bit                         hold_req   = 1'b0;

    rpn_stack_evaluator_unit #(
        .STACK_DEPTH (CALC_DEPTH),
        .VALUE_WIDTH (OUT_W)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_symbol    (in_symbol),
        .i_last      (in_last),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_value     (out_value),
        .o_status    (out_status)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_error(input string what, input logic [OUT_W-1:0] got,
                                input logic [OUT_W-1:0] want);
        $display("ERROR %s: got %0d expected %0d at %0t", what, $signed(got),
                 $signed(want), $realtime);
        err_count++;
    endtask

    // works out the effect of one accepted character, queues the result on a final one
    task automatic evaluate_char(input logic [SYM_W-1:0] sym, input logic is_last);
        logic             is_space;
        logic             is_op;
        t_op              op;
        logic [OUT_W-1:0] lhs;
        logic [OUT_W-1:0] rhs;
        logic [OUT_W-1:0] res;
        logic [OUT_W-1:0] mag_l;
        logic [OUT_W-1:0] mag_r;
        logic             neg_l;
        logic             neg_r;
        t_eval_result     item;
        is_space = (sym >= CH_TAB && sym <= CH_CR) || sym == CH_SPACE;
        is_op = 1'b1;
        op = OP_ADD;
        case (sym)
            CH_PLUS:  op = OP_ADD;
            CH_MINUS: op = OP_SUB;
            CH_STAR:  op = OP_MUL;
            CH_SLASH: op = OP_DIV;
            default:  is_op = 1'b0;
        endcase
        if (is_space) begin
            // skipped, may still close the expression
        end else if (sym >= CH_ZERO && sym <= CH_NINE) begin
            digit_surplus = digit_surplus + 1'b1;
            if (first_error == ST_OK) begin
                if (calc_count >= CALC_DEPTH) begin
                    first_error = ST_OVER;
                end else begin
                    calc_stack[calc_count] = OUT_W'(sym - CH_ZERO);
                    calc_count++;
                end
            end
        end else if (is_op) begin
            digit_surplus = digit_surplus - 1'b1;
            if (first_error == ST_OK) begin
                if (calc_count < 2) begin
                    first_error = ST_UNDER;
                end else begin
                    rhs = calc_stack[calc_count-1];
                    lhs = calc_stack[calc_count-2];
                    res = '0;
                    case (op)
                        OP_ADD: res = lhs + rhs;
                        OP_SUB: res = lhs - rhs;
                        OP_MUL: res = lhs * rhs;
                        default: begin
                            // sign-magnitude division, truncates toward zero
                            neg_l = lhs[OUT_W-1];
                            neg_r = rhs[OUT_W-1];
                            mag_l = neg_l ? -lhs : lhs;
                            mag_r = neg_r ? -rhs : rhs;
                            if (rhs != '0) begin
                                res = mag_l / mag_r;
                            end
                            res = (neg_l != neg_r) ? -res : res;
                        end
                    endcase
                    if (op == OP_DIV && rhs == '0) begin
                        first_error = ST_DIVZERO;
                    end else begin
                        calc_count--;
                        calc_stack[calc_count-1] = res;
                    end
                end
            end
        end else begin
            first_error = ST_INVALID;
        end
        if (is_last) begin
            if (first_error == ST_INVALID || digit_surplus != 1) begin
                item.status = ST_INVALID;
            end else begin
                item.status = first_error;
            end
            item.value = '0;
            if (item.status == ST_OK && calc_count >= 1) begin
                item.value = calc_stack[calc_count-1];
            end
            pending_results.push_back(item);
            calc_count = 0;
            digit_surplus = '0;
            first_error = ST_OK;
        end
    endtask

    // sender: bursts of random length with random gaps, some long unbroken runs
    task automatic send_char(input logic [SYM_W-1:0] sym, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid  <= 1'b1;
        in_symbol <= sym;
        in_last   <= is_last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        evaluate_char(sym, is_last);
        chars_sent++;
    endtask

    task automatic send_chars();
        for (int i = 0; i < expr_chars.size(); i++) begin
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        end
    endtask

    task automatic send_expr(input string text);
        expr_chars.delete();
        for (int i = 0; i < text.len(); i++) begin
            expr_chars.push_back(text[i]);
        end
        send_chars();
    endtask

    function automatic logic [SYM_W-1:0] pick_space();
        logic [SYM_W-1:0] code;
        code = SYM_W'($urandom_range(CH_TAB, CH_CR + 1));
        return (code > CH_CR) ? CH_SPACE : code;
    endfunction

    function automatic logic [SYM_W-1:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // random well-formed postfix expression; push_pct steers the stack depth
    task automatic build_wellformed(input int digit_goal, input int push_pct);
        int depth;
        int left;
        expr_chars.delete();
        depth = 0;
        left = digit_goal;
        while (left > 0 || depth > 1) begin
            if ($urandom_range(0, 9) == 0) begin
                expr_chars.push_back(pick_space());
            end
            if (left > 0 && (depth < 2 || $urandom_range(0, 99) < push_pct)) begin
                expr_chars.push_back(CH_ZERO + SYM_W'($urandom_range(0, 9)));
                depth++;
                left--;
            end else begin
                expr_chars.push_back(pick_op());
                depth--;
            end
        end
        if ($urandom_range(0, 6) == 0) begin
            expr_chars.push_back(pick_space());
        end
    endtask

    // receiver: 16-slot ready pattern replayed, then redrawn at random, plus the long hold-off
    initial begin : rx_pattern
        logic [15:0] pattern;
        int          slot;
        int          hold_cnt;
        pattern = '1;
        slot = 0;
        hold_cnt = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                hold_cnt++;
                if (hold_cnt >= HOLD_CYCLES) begin
                    hold_cnt = 0;
                    hold_req = 1'b0;
                end
            end else begin
                out_ready <= pattern[slot % 16];
                slot++;
                if (slot == 64) begin
                    slot = 0;
                    pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
                end
            end
        end
    end

    // result checker, oldest expectation first
    always @(posedge clk) begin : check_results
        t_eval_result want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_error("result with nothing outstanding", out_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (out_value !== want.value) begin
                    report_error("value", out_value, want.value);
                end
                if (out_status !== want.status) begin
                    report_error("status", OUT_W'(out_status), OUT_W'(want.status));
                end
            end
        end
    end

    task automatic test_digits_and_ops();
        send_expr("0");
        send_expr("9");
        send_expr("9 9+");
        send_expr("3 9-");
        send_expr("9 8*");
        send_expr("9 2/");
        send_expr("0 7-3/");
        send_expr("7 0 2-/");
    endtask

    task automatic test_whitespace();
        logic [SYM_W-1:0] gaps [6];
        gaps = '{CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE};
        expr_chars.delete();
        foreach (gaps[i]) begin
            expr_chars.push_back(gaps[i]);
            expr_chars.push_back(CH_ZERO + SYM_W'(i + 1));
        end
        for (int i = 0; i < 5; i++) begin
            expr_chars.push_back(CH_PLUS);
        end
        expr_chars.push_back(CH_CR);
        send_chars();
        // lone final blank is an empty expression
        send_char(CH_SPACE, 1'b1);
    endtask

    task automatic test_error_status();
        send_expr("a");
        send_char(8'hFF, 1'b1);
        send_char(8'h80, 1'b1);
        send_expr("1 x 2+");
        send_expr("1 2");
        send_expr("1+");
        send_expr("+ 1 1");
        send_expr("5 0/");
        send_expr("0 0/");
        send_expr("5 3 3-/");
        send_expr("5 0/x");
    endtask

    task automatic test_wraparound();
        // eight to the tenth times two is the most negative value
        send_expr("8 8*8*8*8*8*8*8*8*8*2*");
        send_expr("8 8*8*8*8*8*8*8*8*8*2*0 1-/");
        send_expr("9 9*9*9*9*9*9*9*9*9*9*");
    endtask

    task automatic test_stack_limits();
        for (int n = CALC_DEPTH; n <= CALC_DEPTH + 1; n++) begin
            expr_chars.delete();
            for (int i = 0; i < n; i++) begin
                expr_chars.push_back(CH_ZERO + SYM_W'(i % 10));
            end
            for (int i = 0; i < n - 1; i++) begin
                expr_chars.push_back(CH_PLUS);
            end
            send_chars();
        end
    endtask

    task automatic test_output_hold_off();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) begin
            build_wellformed($urandom_range(1, 3), 50);
            send_chars();
        end
    endtask

    task automatic test_random_wellformed();
        int digit_goal;
        while (chars_sent < WELL_CHARS) begin
            digit_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(12, CALC_DEPTH + 2)
                                                     : $urandom_range(1, 7);
            build_wellformed(digit_goal, $urandom_range(30, 90));
            send_chars();
        end
    endtask

    task automatic test_random_broken();
        int kind;
        int pos;
        int n;
        while (chars_sent < TOTAL_CHARS) begin
            kind = $urandom_range(0, 3);
            build_wellformed($urandom_range(1, 5), 60);
            pos = $urandom_range(0, expr_chars.size() - 1);
            case (kind)
                0: expr_chars[pos] = SYM_W'($urandom_range(0, 255));
                1: begin
                    if (expr_chars.size() > 1) begin
                        expr_chars.delete(pos);
                    end
                end
                2: expr_chars.push_back(pick_op());
                default: begin
                    expr_chars.delete();
                    n = $urandom_range(1, 6);
                    repeat (n) expr_chars.push_back(SYM_W'($urandom_range(0, 255)));
                end
            endcase
            send_chars();
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_digits_and_ops();
        test_whitespace();
        test_error_status();
        test_wraparound();
        test_stack_limits();
        test_output_hold_off();
        test_random_wellformed();
        test_random_broken();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/rpn_pkg.sv
sv/rpn_mdu.sv
sv/rpn_dpath.sv
sv/rpn_ctrl.sv
sv/rpn_stack_evaluator_unit.sv
sv/rpn_chk.sv
tb/tb_top.sv
